// ----- hw/rtl/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants, codes and command type of the Pearson correlation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

  localparam int MAX_PAIRS = 1024;
  localparam int CNT_W     = 11;
  localparam int SUM_W     = 19;
  localparam int CROSS_W   = 26;
  localparam int SQ_W      = 25;
  localparam int OP_W      = 27;
  localparam int PROD_W    = 2 * OP_W;
  localparam int ACC_W     = 106;
  localparam int NUM_W     = 38;
  localparam int HALF_W    = 18;
  localparam int P_W       = 70;
  localparam int Q_W       = 16;
  localparam int BIT_W     = 4;
  localparam int SH_W      = 7;
  localparam int STEP_W    = 5;
  localparam int LAST_STEP = 16;

  // multiplier operand selects
  localparam logic [3:0] SEL_N    = 4'd0;
  localparam logic [3:0] SEL_SAB  = 4'd1;
  localparam logic [3:0] SEL_SA   = 4'd2;
  localparam logic [3:0] SEL_SB   = 4'd3;
  localparam logic [3:0] SEL_SAA  = 4'd4;
  localparam logic [3:0] SEL_SBB  = 4'd5;
  localparam logic [3:0] SEL_VALO = 4'd6;
  localparam logic [3:0] SEL_VAHI = 4'd7;
  localparam logic [3:0] SEL_VBLO = 4'd8;
  localparam logic [3:0] SEL_VBHI = 4'd9;
  localparam logic [3:0] SEL_MLO  = 4'd10;
  localparam logic [3:0] SEL_MHI  = 4'd11;

  // accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // accumulator store targets
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_NUM  = 3'd1;
  localparam logic [2:0] ST_VA   = 3'd2;
  localparam logic [2:0] ST_VB   = 3'd3;
  localparam logic [2:0] ST_P    = 3'd4;
  localparam logic [2:0] ST_R    = 3'd5;

  typedef struct packed {
    logic              accum;
    logic              clear;
    logic [1:0]        acc_op;
    logic [3:0]        asel;
    logic [3:0]        bsel;
    logic [SH_W-1:0]   shift;
    logic [2:0]        store;
    logic              search_init;
    logic              search_calc;
    logic              search_commit;
    logic [BIT_W-1:0]  bit_idx;
    logic              load_out;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pearson_correlation_int8_unit.sv -----
// Throughput: one pair per cycle while accumulating; the item marked last
// blocks input through the 17-step multiply program, the 16 search bits (calc
// and commit each) and until the result register can take the new result.
// Reset: rst clears counters, sums, state and result valid; ready on the next cycle.
// ----------------------------------------------------------------------------
// pearson_correlation_int8_unit
// Pearson correlation of signed 8-bit pair windows, Q1.15 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_int8_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [7:0]  sample_a,
  input  wire logic signed [7:0]  sample_b,
  input  wire logic               last_pair,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      correlation,
  output logic                    degenerate,
  output logic                    overflowed
);

  pcc_pkg::cmd_t cmd;

  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_pair (last_pair),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pcc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .correlation (correlation),
    .degenerate  (degenerate),
    .overflowed  (overflowed)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/pcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer: accepts pairs, runs the final arithmetic program and the
// bitwise rounding search, and owns the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          last_pair,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pcc_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MICRO   = 3'd1;
  localparam logic [2:0] S_SINIT   = 3'd2;
  localparam logic [2:0] S_SCALC   = 3'd3;
  localparam logic [2:0] S_SCOMMIT = 3'd4;
  localparam logic [2:0] S_WAIT    = 3'd5;

  logic [2:0]                  state, state_next;
  logic [pcc_pkg::STEP_W-1:0]  step, step_next;
  logic [pcc_pkg::BIT_W-1:0]   bit_idx, bit_idx_next;
  logic                        out_valid_next;

  // Arithmetic program. Accumulator ops land in the cycle after issue (product
  // register), so each store is placed after the op it reads has reached acc.
  function automatic pcc_pkg::cmd_t micro(input logic [pcc_pkg::STEP_W-1:0] s);
    pcc_pkg::cmd_t c;
    c = '0;
    unique case (s)
      5'd0: begin c.acc_op = pcc_pkg::ACC_LOAD; c.asel = pcc_pkg::SEL_N;
        c.bsel = pcc_pkg::SEL_SAB; end
      5'd1: begin c.acc_op = pcc_pkg::ACC_SUB; c.asel = pcc_pkg::SEL_SA;
        c.bsel = pcc_pkg::SEL_SB; end
      5'd2: begin c.acc_op = pcc_pkg::ACC_LOAD; c.asel = pcc_pkg::SEL_N;
        c.bsel = pcc_pkg::SEL_SAA; end
      5'd3: begin c.acc_op = pcc_pkg::ACC_SUB; c.asel = pcc_pkg::SEL_SA;
        c.bsel = pcc_pkg::SEL_SA; c.store = pcc_pkg::ST_NUM; end
      5'd4: begin c.acc_op = pcc_pkg::ACC_LOAD; c.asel = pcc_pkg::SEL_N;
        c.bsel = pcc_pkg::SEL_SBB; end
      5'd5: begin c.acc_op = pcc_pkg::ACC_SUB; c.asel = pcc_pkg::SEL_SB;
        c.bsel = pcc_pkg::SEL_SB; c.store = pcc_pkg::ST_VA; end
      5'd7: begin c.store = pcc_pkg::ST_VB; end
      5'd8: begin c.acc_op = pcc_pkg::ACC_LOAD; c.asel = pcc_pkg::SEL_VALO;
        c.bsel = pcc_pkg::SEL_VBLO; end
      5'd9: begin c.acc_op = pcc_pkg::ACC_ADD; c.asel = pcc_pkg::SEL_VALO;
        c.bsel = pcc_pkg::SEL_VBHI; c.shift = 7'd18; end
      5'd10: begin c.acc_op = pcc_pkg::ACC_ADD; c.asel = pcc_pkg::SEL_VAHI;
        c.bsel = pcc_pkg::SEL_VBLO; c.shift = 7'd18; end
      5'd11: begin c.acc_op = pcc_pkg::ACC_ADD; c.asel = pcc_pkg::SEL_VAHI;
        c.bsel = pcc_pkg::SEL_VBHI; c.shift = 7'd36; end
      5'd12: begin c.acc_op = pcc_pkg::ACC_LOAD; c.asel = pcc_pkg::SEL_MLO;
        c.bsel = pcc_pkg::SEL_MLO; end
      // cross term counted twice: shift 18 + 1
      5'd13: begin c.acc_op = pcc_pkg::ACC_ADD; c.asel = pcc_pkg::SEL_MLO;
        c.bsel = pcc_pkg::SEL_MHI; c.shift = 7'd19; c.store = pcc_pkg::ST_P; end
      5'd14: begin c.acc_op = pcc_pkg::ACC_ADD; c.asel = pcc_pkg::SEL_MHI;
        c.bsel = pcc_pkg::SEL_MHI; c.shift = 7'd36; end
      5'd16: begin c.store = pcc_pkg::ST_R; end
      default: begin c = '0; end
    endcase
    return c;
  endfunction

  always_comb begin
    state_next   = state;
    step_next    = step;
    bit_idx_next = bit_idx;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.accum = in_valid;
        if (in_valid && last_pair) begin
          state_next = S_MICRO;
          step_next  = '0;
        end
      end
      S_MICRO: begin
        cmd       = micro(step);
        step_next = step + 1'b1;
        if (step == pcc_pkg::STEP_W'(pcc_pkg::LAST_STEP)) begin
          state_next = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.search_init = 1'b1;
        bit_idx_next    = '1;
        state_next      = S_SCALC;
      end
      S_SCALC: begin
        cmd.search_calc = 1'b1;
        cmd.bit_idx     = bit_idx;
        state_next      = S_SCOMMIT;
      end
      S_SCOMMIT: begin
        cmd.search_commit = 1'b1;
        cmd.bit_idx       = bit_idx;
        bit_idx_next      = bit_idx - 1'b1;
        state_next        = (bit_idx == '0) ? S_WAIT : S_SCALC;
      end
      S_WAIT: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      bit_idx   <= bit_idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcc_dp.sv -----
// ----------------------------------------------------------------------------
// pcc_dp
// Datapath: window accumulators, shared multiplier with wide accumulator,
// bitwise rounding search and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcc_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pcc_pkg::cmd_t        cmd,
  input  wire logic signed [7:0]    sample_a,
  input  wire logic signed [7:0]    sample_b,
  output logic signed [15:0]        correlation,
  output logic                      degenerate,
  output logic                      overflowed
);

  logic [pcc_pkg::CNT_W-1:0]           cnt;
  logic signed [pcc_pkg::SUM_W-1:0]    sa, sb;
  logic signed [pcc_pkg::CROSS_W-1:0]  sab;
  logic [pcc_pkg::SQ_W-1:0]            saa, sbb;
  logic                                ovf;
  logic signed [15:0]                  p_ab, p_aa, p_bb;

  logic signed [pcc_pkg::OP_W-1:0]     opa, opb;
  logic signed [pcc_pkg::PROD_W-1:0]   prod;
  logic [1:0]                          op_d;
  logic [pcc_pkg::SH_W-1:0]            shift_d;
  logic signed [pcc_pkg::ACC_W-1:0]    acc, term;

  logic signed [pcc_pkg::NUM_W-1:0]    num, va, vb;
  logic [pcc_pkg::NUM_W-1:0]           mag;
  logic [pcc_pkg::P_W-1:0]             pv;
  logic [pcc_pkg::ACC_W-1:0]           rv, tv, uv, cand, pw;
  logic [pcc_pkg::SH_W-1:0]            k3, k2, kk;
  logic [pcc_pkg::Q_W-1:0]             q;
  logic                                degen;

  assign p_ab = sample_a * sample_b;
  assign p_aa = sample_a * sample_a;
  assign p_bb = sample_b * sample_b;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt <= '0;
      sa  <= '0;
      sb  <= '0;
      sab <= '0;
      saa <= '0;
      sbb <= '0;
      ovf <= 1'b0;
    end else if (cmd.accum) begin
      if (cnt == pcc_pkg::CNT_W'(pcc_pkg::MAX_PAIRS)) begin
        ovf <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
        sa  <= sa + pcc_pkg::SUM_W'(sample_a);
        sb  <= sb + pcc_pkg::SUM_W'(sample_b);
        sab <= sab + pcc_pkg::CROSS_W'(p_ab);
        saa <= saa + pcc_pkg::SQ_W'($unsigned(p_aa));
        sbb <= sbb + pcc_pkg::SQ_W'($unsigned(p_bb));
      end
    end
  end

  assign mag = num[pcc_pkg::NUM_W-1] ? $unsigned(-num) : $unsigned(num);

  function automatic logic signed [pcc_pkg::OP_W-1:0] pick(input logic [3:0] s,
      input logic [pcc_pkg::CNT_W-1:0] n_i,
      input logic signed [pcc_pkg::SUM_W-1:0] sa_i, sb_i,
      input logic signed [pcc_pkg::CROSS_W-1:0] sab_i,
      input logic [pcc_pkg::SQ_W-1:0] saa_i, sbb_i,
      input logic [pcc_pkg::NUM_W-1:0] va_i, vb_i, m_i);
    logic signed [pcc_pkg::OP_W-1:0] r;
    r = '0;
    unique case (s)
      pcc_pkg::SEL_N:    r = $signed(pcc_pkg::OP_W'(n_i));
      pcc_pkg::SEL_SAB:  r = pcc_pkg::OP_W'(sab_i);
      pcc_pkg::SEL_SA:   r = pcc_pkg::OP_W'(sa_i);
      pcc_pkg::SEL_SB:   r = pcc_pkg::OP_W'(sb_i);
      pcc_pkg::SEL_SAA:  r = $signed(pcc_pkg::OP_W'(saa_i));
      pcc_pkg::SEL_SBB:  r = $signed(pcc_pkg::OP_W'(sbb_i));
      pcc_pkg::SEL_VALO: r = $signed(pcc_pkg::OP_W'(va_i[17:0]));
      pcc_pkg::SEL_VAHI: r = $signed(pcc_pkg::OP_W'(va_i[35:18]));
      pcc_pkg::SEL_VBLO: r = $signed(pcc_pkg::OP_W'(vb_i[17:0]));
      pcc_pkg::SEL_VBHI: r = $signed(pcc_pkg::OP_W'(vb_i[35:18]));
      pcc_pkg::SEL_MLO:  r = $signed(pcc_pkg::OP_W'(m_i[17:0]));
      pcc_pkg::SEL_MHI:  r = $signed(pcc_pkg::OP_W'(m_i[35:18]));
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign opa  = pick(cmd.asel, cnt, sa, sb, sab, saa, sbb, va, vb, mag);
  assign opb  = pick(cmd.bsel, cnt, sa, sb, sab, saa, sbb, va, vb, mag);
  assign term = pcc_pkg::ACC_W'(prod) <<< shift_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= pcc_pkg::ACC_NONE;
    end else begin
      op_d <= cmd.acc_op;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= opa * opb;
    shift_d <= cmd.shift;
    unique case (op_d)
      pcc_pkg::ACC_LOAD: acc <= term;
      pcc_pkg::ACC_ADD:  acc <= acc + term;
      pcc_pkg::ACC_SUB:  acc <= acc - term;
      default:           acc <= acc;
    endcase
    unique case (cmd.store)
      pcc_pkg::ST_NUM: num <= acc[pcc_pkg::NUM_W-1:0];
      pcc_pkg::ST_VA:  va  <= acc[pcc_pkg::NUM_W-1:0];
      pcc_pkg::ST_VB:  vb  <= acc[pcc_pkg::NUM_W-1:0];
      pcc_pkg::ST_P:   pv  <= acc[pcc_pkg::P_W-1:0];
      pcc_pkg::ST_R:   rv  <= {acc[pcc_pkg::ACC_W-33:0], 32'b0};
      default: begin end
    endcase
  end

  // Greedy search for the largest q with (2q-1)^2 * P <= num^2 * 2^32.
  // tv holds (2q-1)^2 * P and uv holds q * P, both updated by shifts.
  assign pw = pcc_pkg::ACC_W'(pv);
  assign kk = pcc_pkg::SH_W'(cmd.bit_idx);
  assign k3 = kk + 7'd3;
  assign k2 = kk + 7'd2;

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      tv <= pw;
      uv <= '0;
      q  <= '0;
    end else if (cmd.search_calc) begin
      cand <= tv + (uv << k3) + (pw << (kk + k2)) - (pw << k2);
    end else if (cmd.search_commit && cand <= rv) begin
      tv         <= cand;
      uv         <= uv + (pw << kk);
      q[cmd.bit_idx] <= 1'b1;
    end
  end

  assign degen = va[pcc_pkg::NUM_W-1] || (va == '0) || vb[pcc_pkg::NUM_W-1] || (vb == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      degenerate <= degen;
      overflowed <= ovf;
      if (degen) begin
        correlation <= '0;
      end else if (num[pcc_pkg::NUM_W-1]) begin
        correlation <= $signed(-q);
      end else if (q[pcc_pkg::Q_W-1]) begin
        correlation <= 16'sh7FFF;
      end else begin
        correlation <= $signed(q);
      end
    end
  end

endmodule
`default_nettype wire

// ----- dv/pearson_correlation_int8_unit_test.sv -----
// ----------------------------------------------------------------------------
// pearson_correlation_int8_unit_test
// Self-checking bench for the Pearson correlation unit. Pair windows go in
// from a queue. The bench works out each result exactly with wide integers
// and compares every result field by field with the oldest pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_int8_unit_test;

  typedef struct {
    logic signed [7:0] a;
    logic signed [7:0] b;
    logic              last;
  } pair_t;

  typedef struct {
    logic signed [15:0] corr;
    logic               degen;
    logic               ovf;
  } corr_t;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [7:0] sample_a = '0;
  logic signed [7:0] sample_b = '0;
  logic last_pair = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] correlation;
  logic degenerate;
  logic overflowed;

  pair_t pending_pairs[$];
  corr_t expected_corrs[$];
  int errors = 0;
  int pairs_taken = 0;
  int corrs_seen = 0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  // window state of the predictor
  longint win_n, win_sa, win_sb, win_sab, win_saa, win_sbb;
  bit win_ovf;

  pearson_correlation_int8_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_a(sample_a), .sample_b(sample_b), .last_pair(last_pair),
    .out_valid(out_valid), .out_stall(out_stall),
    .correlation(correlation), .degenerate(degenerate), .overflowed(overflowed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("item %0d: %s got %0d want %0d", corrs_seen, what, got, want);
    errors++;
  endtask

  function automatic longint round_q15(input longint mag, input longint va, input longint vb);
    logic [127:0] prod, rhs, lhs, d;
    longint lo, hi, mid;
    prod = 128'(va) * 128'(vb);
    rhs = (128'(mag) * 128'(mag)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic clear_window();
    win_n = 0; win_sa = 0; win_sb = 0; win_sab = 0; win_saa = 0; win_sbb = 0;
    win_ovf = 0;
  endtask

  task automatic accumulate_pair(input pair_t p);
    longint a, b, num, va, vb, q;
    corr_t r;
    a = p.a;
    b = p.b;
    if (win_n < pcc_pkg::MAX_PAIRS) begin
      win_n++;
      win_sa += a; win_sb += b; win_sab += a * b; win_saa += a * a; win_sbb += b * b;
    end else begin
      win_ovf = 1;
    end
    if (p.last) begin
      num = win_n * win_sab - win_sa * win_sb;
      va = win_n * win_saa - win_sa * win_sa;
      vb = win_n * win_sbb - win_sb * win_sb;
      r.corr = '0;
      r.degen = 1'b0;
      r.ovf = win_ovf;
      if (va <= 0 || vb <= 0) begin
        r.degen = 1'b1;
      end else begin
        q = round_q15(num < 0 ? -num : num, va, vb);
        if (num < 0) r.corr = 16'(-q);
        else r.corr = 16'(q > 32767 ? 32767 : q);
      end
      expected_corrs.push_back(r);
      clear_window();
    end
  endtask

  // mode 0: random, 1: b follows a, 2: b mirrors a, 3: a constant
  task automatic push_window(input int len, input int mode);
    pair_t p;
    logic signed [7:0] ca;
    ca = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      p.a = (mode == 3) ? ca : 8'($urandom);
      case (mode)
        1: p.b = p.a;
        2: p.b = ~p.a;
        default: p.b = 8'($urandom);
      endcase
      p.last = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  function automatic pair_t mk(input int a, input int b, input bit last);
    pair_t p;
    p.a = 8'(a); p.b = 8'(b); p.last = last;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    bit take;
    bit calm;
    pair_t p;
    if (!rst) begin
      take = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        accumulate_pair('{sample_a, sample_b, last_pair});
        pairs_taken++;
      end
      if (take) begin
        calm = pairs_taken >= 300 && pairs_taken < 600;
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          p = pending_pairs.pop_front();
          sample_a <= p.a;
          sample_b <= p.b;
          last_pair <= p.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    corr_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_corrs.size() == 0) begin
          report_mismatch("unexpected result, correlation", correlation, 0);
        end else begin
          e = expected_corrs.pop_front();
          if (correlation !== e.corr) report_mismatch("correlation", correlation, e.corr);
          if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
          if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
        end
        corrs_seen++;
      end
      if (!hold_done && corrs_seen == 8) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= hold_left > 1;
      end else if (corrs_seen >= 30 && corrs_seen < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= $urandom_range(99) < 19;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || stim_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int budget;
    clear_window();
    // single pair: no variance
    pending_pairs.push_back(mk(0, 0, 1));
    // full positive and full negative correlation at the extremes
    pending_pairs.push_back(mk(-128, -128, 0));
    pending_pairs.push_back(mk(127, 127, 1));
    pending_pairs.push_back(mk(-128, 127, 0));
    pending_pairs.push_back(mk(127, -128, 1));
    // one sample constant
    pending_pairs.push_back(mk(5, -3, 0));
    pending_pairs.push_back(mk(5, 90, 0));
    pending_pairs.push_back(mk(5, -128, 1));
    // both constant
    pending_pairs.push_back(mk(-1, 127, 0));
    pending_pairs.push_back(mk(-1, 127, 1));
    // small mixed window
    pending_pairs.push_back(mk(1, 2, 0));
    pending_pairs.push_back(mk(-7, 3, 0));
    pending_pairs.push_back(mk(64, -60, 0));
    pending_pairs.push_back(mk(0, 1, 1));
    // window overruns the pair limit, last item among the ignored ones
    push_window(pcc_pkg::MAX_PAIRS + 3, 0);
    budget = 300;
    while (budget > 0) begin
      int len, mode;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(8, 1);
      mode = $urandom_range(9);
      mode = mode < 6 ? 0 : mode - 6;
      push_window(len, mode);
      budget -= len;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (expected_corrs.size() == 0);
    stim_done = 1'b1;
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_corrs.size() == 0 && !out_valid) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
